FILE: rtl/bipartite_skip_flag_closure_top_macros.svh
// Assertion macros for the skip-flag closure block.
// Used by the top level. The including module must have a clk and a rst signal.
`ifndef BIPARTITE_SKIP_FLAG_CLOSURE_TOP_MACROS_SVH
`define BIPARTITE_SKIP_FLAG_CLOSURE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bsfc_pkg.sv
// Shared types and constants for the skip-flag closure block.
// No dependencies. The top level and the register module use it.
package bsfc_pkg;

  localparam int MAX_NODES_DEF  = 256;
  localparam int LIST_DEPTH_DEF = 16;

  // Command codes of the input word.
  localparam logic [2:0] CMD_LOAD_EARLY  = 3'd0;
  localparam logic [2:0] CMD_LOAD_LATE   = 3'd1;
  localparam logic [2:0] CMD_APPEND_SUCC = 3'd2;
  localparam logic [2:0] CMD_APPEND_PRED = 3'd3;
  localparam logic [2:0] CMD_RUN         = 3'd4;
  localparam logic [2:0] CMD_READ       = 3'd5;

  // Register map.
  localparam int           PADDR_W      = 3;
  localparam logic [2:0]   REG_CUTOFF   = 3'd0;

  localparam logic [7:0]   SUCC_LIMIT   = 8'd2;
  localparam logic [9:0]   COUNT_MAX    = 10'd1023;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        side;
    logic [7:0]  node_index;
    logic        node_valid;
    logic [7:0]  hard_count;
    logic [7:0]  total_count;
    logic        initial_flag;
    logic [15:0] partner_distance;
    logic        partner_available;
    logic [7:0]  partner_index;
  } in_word_t;

  typedef struct packed {
    logic        flag_value;
    logic [9:0]  marked_count;
    logic        run_done;
  } out_word_t;

  // One partner list entry as stored.
  typedef struct packed {
    logic [15:0] distance;
    logic        avail;
    logic [7:0]  idx;
  } entry_t;

endpackage

FILE: rtl/bipartite_skip_flag_closure_top.sv
// Top level of the skip-flag closure block: sequencer, node memory and list memory.
// Depends on bsfc_pkg, bsfc_cfg and the assertion macro header.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_stall  | bsfc_pkg::in_word_t
//   out     | output    | out_valid/out_stall| bsfc_pkg::out_word_t
//   cfg     | input     | APB psel/penable   | distance cutoff
//
// After reset a clearing pass writes every node entry, with stall held high.
// Loads and appends pass through three steps: accept, node memory read, write back; a read
// takes a fourth step to move its result into the output register.
// A run first reads and tests each earlier node for the count test, then makes
// repeated passes over both sides, reading and checking each node and each walked
// list entry, updating the target of each usable entry and closing each walk,
// until a pass flags nothing. The node memory has a single read port.
// A waiting result does not block loads; a new result waits until the old one is taken.
`include "bipartite_skip_flag_closure_top_macros.svh"

module bipartite_skip_flag_closure_top #(
  parameter int MAX_NODES  = bsfc_pkg::MAX_NODES_DEF,
  parameter int LIST_DEPTH = bsfc_pkg::LIST_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bsfc_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bsfc_pkg::out_word_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsfc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int SW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int AW = 1 + NW + SW;

  typedef struct packed {
    logic          e_valid;
    logic [7:0]    e_hard;
    logic [7:0]    e_total;
    logic          e_flag;
    logic [LW-1:0] s_len;
    logic          l_valid;
    logic          l_flag;
    logic [LW-1:0] p_len;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_OP_RD, ST_OP_EX, ST_RESP, ST_INIT_RD, ST_INIT_EX,
    ST_SW_RD, ST_SW_CHK, ST_LS_RD, ST_LS_CHK, ST_TG_EX
  } state_t;

  logic [15:0] cutoff;

  bsfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cutoff  (cutoff)
  );

  // Memories.
  node_t           node_mem [2**NW];
  bsfc_pkg::entry_t list_mem [2**AW];
  node_t           node_q;
  bsfc_pkg::entry_t list_q;
  logic [NW-1:0]   node_raddr, node_waddr;
  logic            node_we;
  node_t           node_wdata;
  logic [AW-1:0]   list_raddr, list_waddr;
  logic            list_we;
  bsfc_pkg::entry_t list_wdata;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_q <= list_mem[list_raddr];
  end

  // Sequencer state.
  state_t              st;
  bsfc_pkg::in_word_t  req;
  logic [CW-1:0]       i;
  logic [LW-1:0]       k;
  logic [LW-1:0]       cur_len;
  logic [NW-1:0]       tgt;
  logic                sside;
  logic                changed;
  logic [9:0]          cnt;
  logic [CW-1:0]       early_count, late_count;
  bsfc_pkg::out_word_t res;

  logic          req_in_range;
  logic [NW-1:0] req_node;
  logic [CW-1:0] req_next_count;
  logic [CW-1:0] src_count, dst_count;
  logic          init_hit, src_live, tgt_clear, entry_ok, walk_end;
  logic [9:0]    cnt_inc;

  assign req_in_range   = 32'(req.node_index) < MAX_NODES;
  assign req_node       = NW'(req.node_index);
  assign req_next_count = CW'(32'(req.node_index) + 1);
  assign src_count      = sside ? late_count : early_count;
  assign dst_count      = sside ? early_count : late_count;
  assign cnt_inc        = (cnt == bsfc_pkg::COUNT_MAX) ? cnt : cnt + 10'd1;

  assign init_hit = node_q.e_valid && !node_q.e_flag &&
                    ((node_q.e_hard > bsfc_pkg::SUCC_LIMIT) ||
                     ({1'b0, node_q.e_total} > ({1'b0, node_q.e_hard} + {1'b0, bsfc_pkg::SUCC_LIMIT})));
  assign src_live  = sside ? (node_q.l_valid && node_q.l_flag)
                           : (node_q.e_valid && node_q.e_flag);
  assign tgt_clear = sside ? !node_q.e_flag : !node_q.l_flag;
  assign entry_ok  = list_q.avail && (32'(list_q.idx) < 32'(dst_count));
  assign walk_end  = (k == cur_len) || (32'(k) >= 32'(dst_count));

  assign in_stall = (st != ST_IDLE);

  always_comb begin
    node_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = node_q;
    list_raddr = '0;
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = '{distance: req.partner_distance, avail: req.partner_available,
                   idx: req.partner_index};
    unique case (st)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = NW'(i);
        node_wdata = '0;
      end
      ST_OP_RD: node_raddr = req_node;
      ST_OP_EX: begin
        node_waddr = req_node;
        if (req_in_range) begin
          priority case (req.cmd)
            bsfc_pkg::CMD_LOAD_EARLY: begin
              node_we            = 1'b1;
              node_wdata.e_valid = req.node_valid;
              node_wdata.e_hard  = req.hard_count;
              node_wdata.e_total = req.total_count;
              node_wdata.e_flag  = req.initial_flag;
              node_wdata.s_len   = '0;
            end
            bsfc_pkg::CMD_LOAD_LATE: begin
              node_we            = 1'b1;
              node_wdata.l_valid = req.node_valid;
              node_wdata.l_flag  = req.initial_flag;
              node_wdata.p_len   = '0;
            end
            bsfc_pkg::CMD_APPEND_SUCC: begin
              if (32'(node_q.s_len) < LIST_DEPTH) begin
                node_we          = 1'b1;
                node_wdata.s_len = node_q.s_len + LW'(1);
                list_we          = 1'b1;
                list_waddr       = {1'b0, req_node, SW'(node_q.s_len)};
              end
            end
            bsfc_pkg::CMD_APPEND_PRED: begin
              if (32'(node_q.p_len) < LIST_DEPTH) begin
                node_we          = 1'b1;
                node_wdata.p_len = node_q.p_len + LW'(1);
                list_we          = 1'b1;
                list_waddr       = {1'b1, req_node, SW'(node_q.p_len)};
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT_RD: node_raddr = NW'(i);
      ST_INIT_EX: begin
        node_waddr        = NW'(i);
        node_wdata.e_flag = 1'b1;
        node_we           = init_hit;
      end
      ST_SW_RD:  node_raddr = NW'(i);
      ST_LS_RD:  list_raddr = {sside, NW'(i), SW'(k)};
      ST_LS_CHK: node_raddr = NW'(list_q.idx);
      ST_TG_EX: begin
        node_waddr = tgt;
        node_we    = tgt_clear;
        if (sside) begin
          node_wdata.e_flag = 1'b1;
        end else begin
          node_wdata.l_flag = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_CLEAR;
      i           <= '0;
      k           <= '0;
      cur_len     <= '0;
      tgt         <= '0;
      sside       <= 1'b0;
      changed     <= 1'b0;
      cnt         <= '0;
      early_count <= '0;
      late_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The result state loads the output register itself when the old word leaves.
      if (out_valid && !out_stall && (st != ST_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_CLEAR: begin
          if (32'(i) == MAX_NODES - 1) begin
            i  <= '0;
            st <= ST_IDLE;
          end else begin
            i <= i + CW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            if (in_data.cmd == bsfc_pkg::CMD_RUN) begin
              cnt <= '0;
              i   <= '0;
              st  <= ST_INIT_RD;
            end else if (in_data.cmd <= bsfc_pkg::CMD_READ) begin
              st <= ST_OP_RD;
            end
          end
        end
        ST_OP_RD: st <= ST_OP_EX;
        ST_OP_EX: begin
          st <= ST_IDLE;
          if (req_in_range && (req.cmd == bsfc_pkg::CMD_LOAD_EARLY) &&
              (req_next_count > early_count)) begin
            early_count <= req_next_count;
          end
          if (req_in_range && (req.cmd == bsfc_pkg::CMD_LOAD_LATE) &&
              (req_next_count > late_count)) begin
            late_count <= req_next_count;
          end
          if (req.cmd == bsfc_pkg::CMD_READ) begin
            res.flag_value   <= req_in_range && (req.side ? node_q.l_flag : node_q.e_flag);
            res.marked_count <= '0;
            res.run_done     <= 1'b0;
            st               <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        ST_INIT_RD: begin
          if (i == early_count) begin
            i       <= '0;
            sside   <= 1'b0;
            changed <= 1'b0;
            st      <= ST_SW_RD;
          end else begin
            st <= ST_INIT_EX;
          end
        end
        ST_INIT_EX: begin
          if (init_hit) begin
            cnt <= cnt_inc;
          end
          i  <= i + CW'(1);
          st <= ST_INIT_RD;
        end
        ST_SW_RD: begin
          if (i == src_count) begin
            i <= '0;
            if (!sside) begin
              sside <= 1'b1;
            end else if (changed) begin
              sside   <= 1'b0;
              changed <= 1'b0;
            end else begin
              res.flag_value   <= 1'b0;
              res.marked_count <= cnt;
              res.run_done     <= 1'b1;
              st               <= ST_RESP;
            end
          end else begin
            st <= ST_SW_CHK;
          end
        end
        ST_SW_CHK: begin
          if (src_live) begin
            cur_len <= sside ? node_q.p_len : node_q.s_len;
            k       <= '0;
            st      <= ST_LS_RD;
          end else begin
            i  <= i + CW'(1);
            st <= ST_SW_RD;
          end
        end
        ST_LS_RD: begin
          if (walk_end) begin
            i  <= i + CW'(1);
            st <= ST_SW_RD;
          end else begin
            st <= ST_LS_CHK;
          end
        end
        ST_LS_CHK: begin
          // An entry beyond the cutoff ends the walk; an unusable one is skipped.
          if (list_q.distance > cutoff) begin
            i  <= i + CW'(1);
            st <= ST_SW_RD;
          end else if (entry_ok) begin
            tgt <= NW'(list_q.idx);
            st  <= ST_TG_EX;
          end else begin
            k  <= k + LW'(1);
            st <= ST_LS_RD;
          end
        end
        ST_TG_EX: begin
          if (tgt_clear) begin
            cnt     <= cnt_inc;
            changed <= 1'b1;
          end
          k  <= k + LW'(1);
          st <= ST_LS_RD;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `BSFC_ASSERT_NOW(a_read_no_count, out_valid && !out_data.run_done, out_data.marked_count == '0, "read result carries a count")
  `BSFC_ASSERT_NOW(a_walk_in_list, st == ST_LS_CHK, k < cur_len, "list walk past its length")
  `BSFC_ASSERT_NOW(a_sweep_bound, st == ST_SW_RD, i <= src_count, "node sweep past node count")
  `BSFC_ASSERT_NEXT(a_target_write, st == ST_TG_EX, st == ST_LS_RD, "target update did not resume walk")

endmodule

FILE: rtl/bsfc_cfg.sv
// APB register file of the skip-flag closure block: holds the distance cutoff.
// Depends on bsfc_pkg.
module bsfc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsfc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  cutoff
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= '0;
    end else if (psel && penable && pwrite && (paddr == bsfc_pkg::REG_CUTOFF)) begin
      cutoff <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == bsfc_pkg::REG_CUTOFF) begin
      prdata = {16'd0, cutoff};
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the skip-flag closure block: loads node sets and partner lists,
// runs the closure and reads flags back, predicting every result word in a local model.
// Depends on bsfc_pkg and the bipartite_skip_flag_closure_top RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int NODES = bsfc_pkg::MAX_NODES_DEF;
  localparam int DEPTH = bsfc_pkg::LIST_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bsfc_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bsfc_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bsfc_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bipartite_skip_flag_closure_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the block state.
  logic [15:0] cutoff;
  logic        e_valid [NODES];
  logic [7:0]  e_hard [NODES];
  logic [7:0]  e_total [NODES];
  logic        e_flag [NODES];
  logic        l_valid [NODES];
  logic        l_flag [NODES];
  bsfc_pkg::entry_t succ_tab [NODES][DEPTH];
  bsfc_pkg::entry_t pred_tab [NODES][DEPTH];
  int          succ_len [NODES];
  int          pred_len [NODES];
  int          e_cnt;
  int          l_cnt;

  bsfc_pkg::out_word_t expected_words_q[$];
  int mismatches = 0;
  int words_sent = 0;
  bit idle_on = 1'b1;

  // Walks one list from its head and flags partners on the other side.
  function automatic int flag_partners(bit from_late, int i);
    int len;
    int dcnt;
    int lim;
    int n;
    bsfc_pkg::entry_t e;
    len = from_late ? pred_len[i] : succ_len[i];
    dcnt = from_late ? e_cnt : l_cnt;
    lim = (len < dcnt) ? len : dcnt;
    n = 0;
    for (int k = 0; k < lim; k++) begin
      e = from_late ? pred_tab[i][k] : succ_tab[i][k];
      if (e.distance > cutoff) break;
      if (e.avail && int'(e.idx) < dcnt) begin
        if (from_late && !e_flag[e.idx]) begin
          e_flag[e.idx] = 1'b1;
          n++;
        end else if (!from_late && !l_flag[e.idx]) begin
          l_flag[e.idx] = 1'b1;
          n++;
        end
      end
    end
    return n;
  endfunction

  function automatic int close_flags();
    int total;
    int n;
    bit changed;
    total = 0;
    for (int i = 0; i < e_cnt; i++) begin
      if (e_valid[i] && !e_flag[i] &&
          (e_hard[i] > 8'd2 || int'(e_total[i]) > int'(e_hard[i]) + 2)) begin
        e_flag[i] = 1'b1;
        total++;
      end
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < e_cnt; i++) begin
        if (e_valid[i] && e_flag[i]) begin
          n = flag_partners(1'b0, i);
          if (n != 0) begin
            total += n;
            changed = 1'b1;
          end
        end
      end
      for (int i = 0; i < l_cnt; i++) begin
        if (l_valid[i] && l_flag[i]) begin
          n = flag_partners(1'b1, i);
          if (n != 0) begin
            total += n;
            changed = 1'b1;
          end
        end
      end
    end
    return (total > 1023) ? 1023 : total;
  endfunction

  // Applies one accepted word to the local state and queues its result, if any.
  function automatic void predict_word(bsfc_pkg::in_word_t w);
    int ni;
    bsfc_pkg::entry_t e;
    bsfc_pkg::out_word_t r;
    ni = int'(w.node_index);
    e.distance = w.partner_distance;
    e.avail = w.partner_available;
    e.idx = w.partner_index;
    case (w.cmd)
      bsfc_pkg::CMD_LOAD_EARLY: begin
        e_valid[ni] = w.node_valid;
        e_hard[ni] = w.hard_count;
        e_total[ni] = w.total_count;
        e_flag[ni] = w.initial_flag;
        succ_len[ni] = 0;
        if (ni + 1 > e_cnt) e_cnt = ni + 1;
      end
      bsfc_pkg::CMD_LOAD_LATE: begin
        l_valid[ni] = w.node_valid;
        l_flag[ni] = w.initial_flag;
        pred_len[ni] = 0;
        if (ni + 1 > l_cnt) l_cnt = ni + 1;
      end
      bsfc_pkg::CMD_APPEND_SUCC: begin
        if (succ_len[ni] < DEPTH) begin
          succ_tab[ni][succ_len[ni]] = e;
          succ_len[ni]++;
        end
      end
      bsfc_pkg::CMD_APPEND_PRED: begin
        if (pred_len[ni] < DEPTH) begin
          pred_tab[ni][pred_len[ni]] = e;
          pred_len[ni]++;
        end
      end
      bsfc_pkg::CMD_RUN: begin
        r.flag_value = 1'b0;
        r.marked_count = 10'(close_flags());
        r.run_done = 1'b1;
        expected_words_q.push_back(r);
      end
      bsfc_pkg::CMD_READ: begin
        r.flag_value = w.side ? l_flag[ni] : e_flag[ni];
        r.marked_count = '0;
        r.run_done = 1'b0;
        expected_words_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Sends one word; valid stays high after acceptance until the next gap or pause.
  task automatic send_word(bsfc_pkg::in_word_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    words_sent++;
  endtask

  function automatic bsfc_pkg::in_word_t noise_word(logic [2:0] cmd);
    bsfc_pkg::in_word_t w;
    w = bsfc_pkg::in_word_t'($bits(bsfc_pkg::in_word_t)'({$urandom, $urandom}));
    w.cmd = cmd;
    return w;
  endfunction

  task automatic load_node(logic [2:0] cmd, int ni, bit vld, int hard, int tot, bit flag);
    bsfc_pkg::in_word_t w;
    w = noise_word(cmd);
    w.node_index = 8'(ni);
    w.node_valid = vld;
    w.hard_count = 8'(hard);
    w.total_count = 8'(tot);
    w.initial_flag = flag;
    send_word(w);
  endtask

  task automatic append_entry(logic [2:0] cmd, int ni, int dist_v, bit avail, int pidx);
    bsfc_pkg::in_word_t w;
    w = noise_word(cmd);
    w.node_index = 8'(ni);
    w.partner_distance = 16'(dist_v);
    w.partner_available = avail;
    w.partner_index = 8'(pidx);
    send_word(w);
  endtask

  task automatic read_flag(bit side, int ni);
    bsfc_pkg::in_word_t w;
    w = noise_word(bsfc_pkg::CMD_READ);
    w.side = side;
    w.node_index = 8'(ni);
    send_word(w);
  endtask

  // Drops valid and waits until the block has returned everything and gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [15:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bsfc_pkg::REG_CUTOFF;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cutoff = value;
  endtask

  task automatic test_reset_state();
    read_flag(1'b0, 0);
    read_flag(1'b1, 255);
    send_word(noise_word(bsfc_pkg::CMD_RUN));
  endtask

  // Count thresholds, soft count below zero, invalid nodes and the cutoff boundary.
  task automatic test_thresholds();
    write_cutoff(16'hFFFF);
    load_node(bsfc_pkg::CMD_LOAD_EARLY, 0, 1'b1, 3, 3, 1'b0);
    load_node(bsfc_pkg::CMD_LOAD_EARLY, 1, 1'b1, 0, 3, 1'b0);
    load_node(bsfc_pkg::CMD_LOAD_EARLY, 2, 1'b1, 1, 0, 1'b0);
    load_node(bsfc_pkg::CMD_LOAD_EARLY, 3, 1'b0, 255, 255, 1'b0);
    load_node(bsfc_pkg::CMD_LOAD_LATE, 0, 1'b1, 0, 0, 1'b0);
    load_node(bsfc_pkg::CMD_LOAD_LATE, 1, 1'b0, 0, 0, 1'b1);
    append_entry(bsfc_pkg::CMD_APPEND_SUCC, 0, 16'hFFFF, 1'b1, 0);
    append_entry(bsfc_pkg::CMD_APPEND_SUCC, 1, 0, 1'b1, 7);
    append_entry(bsfc_pkg::CMD_APPEND_SUCC, 1, 0, 1'b0, 1);
    append_entry(bsfc_pkg::CMD_APPEND_PRED, 0, 0, 1'b1, 3);
    append_entry(bsfc_pkg::CMD_APPEND_PRED, 1, 0, 1'b1, 2);
    send_word(noise_word(CMD_SPARE_A));
    send_word(noise_word(CMD_SPARE_B));
    send_word(noise_word(bsfc_pkg::CMD_RUN));
    read_flag(1'b0, 2);
    read_flag(1'b0, 3);
    read_flag(1'b1, 0);
    send_word(noise_word(bsfc_pkg::CMD_RUN));
    write_cutoff(16'h0000);
    load_node(bsfc_pkg::CMD_LOAD_EARLY, 4, 1'b1, 0, 0, 1'b1);
    append_entry(bsfc_pkg::CMD_APPEND_SUCC, 4, 1, 1'b1, 1);
    send_word(noise_word(bsfc_pkg::CMD_RUN));
  endtask

  function automatic int pick_dist();
    int hi;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 16'hFFFF);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, cutoff);
    hi = (int'(cutoff) + 64 > 16'hFFFF) ? 16'hFFFF : int'(cutoff) + 64;
    return $urandom_range(cutoff, hi);
  endfunction

  function automatic int pick_count();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 255);
  endfunction

  // Builds small random graphs, runs the closure and reads flags back.
  task automatic test_random_graphs(int target, bit wide);
    int ne;
    int nl;
    int ni;
    int pidx;
    bit to_late;
    while (words_sent < target) begin
      ne = $urandom_range(1, 12);
      nl = $urandom_range(1, 12);
      if (wide && $urandom_range(0, 2) == 0) begin
        load_node($urandom_range(0, 1) ? bsfc_pkg::CMD_LOAD_LATE : bsfc_pkg::CMD_LOAD_EARLY,
                  $urandom_range(128, 255), $urandom_range(0, 1), pick_count(),
                  pick_count(), $urandom_range(0, 1));
      end
      for (int i = 0; i < ne; i++)
        load_node(bsfc_pkg::CMD_LOAD_EARLY, i, $urandom_range(0, 3) != 0, pick_count(),
                  pick_count(), $urandom_range(0, 7) == 0);
      for (int i = 0; i < nl; i++)
        load_node(bsfc_pkg::CMD_LOAD_LATE, i, $urandom_range(0, 3) != 0, 0, 0,
                  $urandom_range(0, 7) == 0);
      repeat ($urandom_range(0, 3 * (ne + nl))) begin
        to_late = $urandom_range(0, 1);
        ni = $urandom_range(0, to_late ? nl - 1 : ne - 1);
        if ($urandom_range(0, 15) == 0) ni = $urandom_range(0, 255);
        pidx = $urandom_range(0, to_late ? e_cnt : l_cnt);
        if ($urandom_range(0, 15) == 0) pidx = $urandom_range(0, 255);
        // Now and then fill one list well past its depth.
        repeat (($urandom_range(0, 20) == 0) ? 18 : 1)
          append_entry(to_late ? bsfc_pkg::CMD_APPEND_PRED : bsfc_pkg::CMD_APPEND_SUCC, ni,
                       pick_dist(), $urandom_range(0, 7) != 0, pidx);
      end
      if ($urandom_range(0, 5) == 0)
        send_word(noise_word($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B));
      send_word(noise_word(bsfc_pkg::CMD_RUN));
      if ($urandom_range(0, 4) == 0) send_word(noise_word(bsfc_pkg::CMD_RUN));
      repeat ($urandom_range(2, 8)) begin
        to_late = $urandom_range(0, 1);
        ni = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, to_late ? nl - 1 : ne - 1);
        read_flag(to_late, ni);
      end
    end
  endtask

  // Random out_stall bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(string name, int exp_v, int got_v);
    $display("%0t: mismatch on %s: expected %0d actual %0d", $time, name, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bsfc_pkg::out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words_q.size() == 0) begin
        $display("%0t: unexpected word: expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        exp_w = expected_words_q.pop_front();
        if (out_data.flag_value !== exp_w.flag_value)
          report_field("flag_value", int'(exp_w.flag_value), int'(out_data.flag_value));
        if (out_data.marked_count !== exp_w.marked_count)
          report_field("marked_count", int'(exp_w.marked_count), int'(out_data.marked_count));
        if (out_data.run_done !== exp_w.run_done)
          report_field("run_done", int'(exp_w.run_done), int'(out_data.run_done));
      end
    end
  end

  initial begin
    cutoff = '0;
    e_cnt = 0;
    l_cnt = 0;
    for (int i = 0; i < NODES; i++) begin
      e_valid[i] = 1'b0;
      e_flag[i] = 1'b0;
      l_valid[i] = 1'b0;
      l_flag[i] = 1'b0;
      succ_len[i] = 0;
      pred_len[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_thresholds();
    write_cutoff(16'hFFFF);
    test_random_graphs(500, 1'b0);
    write_cutoff(16'($urandom_range(0, 16'hFFFF)));
    test_random_graphs(900, 1'b0);
    write_cutoff(16'h0800);
    test_random_graphs(1300, 1'b0);
    write_cutoff(16'h0000);
    test_random_graphs(1600, 1'b0);
    write_cutoff(16'($urandom_range(16'h0100, 16'h2000)));
    idle_on = 1'b0;
    test_random_graphs(1850, 1'b1);
    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_words_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bsfc_pkg.sv
rtl/bsfc_cfg.sv
rtl/bipartite_skip_flag_closure_top.sv
dv/tb_top.sv
